// ===== sv/amiq_pkg.sv =====
// Shared widths, latencies and helper functions for the initial quaternion core.
// No dependencies; imported by every module of the block.
package amiq_pkg;

  localparam int F        = 14;
  localparam int ONE      = 1 << F;
  localparam int CW       = F + 2;
  localparam int SQW      = 31;
  localparam int SXW      = 62;
  localparam int STW      = 64;
  localparam int NW       = F + 32;
  localparam int QW       = F + 1;
  localparam int PW       = 2 * CW;
  localparam int PDW      = PW + 1;
  localparam int QXW      = 2 * F + 1;
  localparam int QRW      = F + 1;
  localparam int QTW      = 2 * F + 3;
  localparam int AW       = F + 4;
  localparam int VW       = QRW + 2;
  localparam int NORM_LAT = 2 + SQW + 1 + QW + 1;
  localparam int QUAT_LAT = 5 + QRW + 1;
  localparam int LAT      = NORM_LAT + QUAT_LAT;

  typedef logic signed [15:0]   raw_t;
  typedef logic signed [CW-1:0] comp_t;
  typedef logic signed [PW-1:0] prod_t;

  function automatic comp_t rescale(input logic signed [PW:0] d);
    logic [PW:0]   u;
    logic [PW:0]   r;
    logic [CW-1:0] m;
    u = d[PW] ? (~d + 1'b1) : d;
    r = (u + PDW'(1 << (F - 1))) >> F;
    m = (r > PDW'(ONE)) ? CW'(ONE) : r[CW-1:0];
    return d[PW] ? -signed'(m) : signed'(m);
  endfunction

  function automatic logic [15:0] pack16(input logic signed [VW-1:0] v);
    logic signed [40:0] w;
    w = 41'(v);
    if (w > 41'sd32767) return 16'h7fff;
    if (w < -41'sd32768) return 16'h8000;
    return w[15:0];
  endfunction

endpackage

// ===== sv/amiq_norm.sv =====
// Normalizes one raw 3-vector to unit length: squares, bit-serial square root
// stages and restoring divide stages. Depends on amiq_pkg.
module amiq_norm (
  input  logic                    clk,
  input  logic                    en,
  input  amiq_pkg::raw_t  [2:0]   vec_i,
  output amiq_pkg::comp_t [2:0]   unit_o,
  output logic                    zero_o
);
  import amiq_pkg::*;

  typedef struct packed {
    logic [2:0][15:0] mag;
    logic [2:0]       neg;
  } side_t;

  logic [2:0][31:0] sq_r;
  side_t            s1_r;

  logic [SXW-1:0] sr_rem_r  [SQW+1];
  logic [SQW-1:0] sr_root_r [SQW+1];
  side_t          sr_side_r [SQW+1];
  logic           sr_zero_r [SQW+1];

  logic [2:0][NW-1:0] dv_rem_r  [QW+1];
  logic [2:0][QW-1:0] dv_q_r    [QW+1];
  logic [SQW-1:0]     dv_root_r [QW+1];
  logic [2:0]         dv_neg_r  [QW+1];
  logic               dv_zero_r [QW+1];

  logic [33:0] sum;
  comp_t [2:0] unit_r;
  logic        zero_r;

  assign sum = 34'(sq_r[0]) + 34'(sq_r[1]) + 34'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k]        <= 32'(vec_i[k] * vec_i[k]);
        s1_r.neg[k]    <= vec_i[k][15];
        s1_r.mag[k]    <= vec_i[k][15] ? 16'(-vec_i[k]) : 16'(vec_i[k]);
      end
      sr_rem_r[0]  <= {sum[31:0], 30'b0};
      sr_root_r[0] <= '0;
      sr_side_r[0] <= s1_r;
      sr_zero_r[0] <= (sum == '0);
    end
  end

  for (genvar k = 0; k < SQW; k++) begin : g_sqrt
    localparam int I = SQW - 1 - k;
    logic [STW-1:0] trial;
    logic           take;
    assign trial = (STW'(sr_root_r[k]) << (I + 1)) | (STW'(1) << (2 * I));
    assign take  = STW'(sr_rem_r[k]) >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sr_rem_r[k+1]  <= take ? SXW'(STW'(sr_rem_r[k]) - trial) : sr_rem_r[k];
        sr_root_r[k+1] <= take ? (sr_root_r[k] | (SQW'(1) << I)) : sr_root_r[k];
        sr_side_r[k+1] <= sr_side_r[k];
        sr_zero_r[k+1] <= sr_zero_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dv_rem_r[0][k] <= (NW'(sr_side_r[SQW].mag[k]) << (F + 15))
                          + NW'(sr_root_r[SQW] >> 1);
        dv_q_r[0][k]   <= '0;
      end
      dv_root_r[0] <= sr_root_r[SQW];
      dv_neg_r[0]  <= sr_side_r[SQW].neg;
      dv_zero_r[0] <= sr_zero_r[SQW];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int I = QW - 1 - j;
    logic [NW-1:0] dsh;
    assign dsh = NW'(dv_root_r[j]) << I;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          if (dv_rem_r[j][k] >= dsh) begin
            dv_rem_r[j+1][k] <= dv_rem_r[j][k] - dsh;
            dv_q_r[j+1][k]   <= dv_q_r[j][k] | (QW'(1) << I);
          end else begin
            dv_rem_r[j+1][k] <= dv_rem_r[j][k];
            dv_q_r[j+1][k]   <= dv_q_r[j][k];
          end
        end
        dv_root_r[j+1] <= dv_root_r[j];
        dv_neg_r[j+1]  <= dv_neg_r[j];
        dv_zero_r[j+1] <= dv_zero_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (dv_zero_r[QW]) begin
          unit_r[k] <= '0;
        end else if (dv_q_r[QW][k] > QW'(ONE)) begin
          unit_r[k] <= dv_neg_r[QW][k] ? -comp_t'(ONE) : comp_t'(ONE);
        end else begin
          unit_r[k] <= dv_neg_r[QW][k] ? -signed'(CW'(dv_q_r[QW][k]))
                                       : signed'(CW'(dv_q_r[QW][k]));
        end
      end
      zero_r <= dv_zero_r[QW];
    end
  end

  assign unit_o = unit_r;
  assign zero_o = zero_r;

endmodule

// ===== sv/amiq_quat.sv =====
// Builds the rotation columns from two unit vectors and extracts the quaternion
// through cross-product stages and bit-serial square roots. Depends on amiq_pkg.
module amiq_quat (
  input  logic                  clk,
  input  logic                  en,
  input  amiq_pkg::comp_t [2:0] a_i,
  input  amiq_pkg::comp_t [2:0] m_i,
  input  logic [1:0]            flag_i,
  output logic [63:0]           quat_o,
  output logic [1:0]            flag_o
);
  import amiq_pkg::*;

  typedef struct packed {
    comp_t [2:0] a;
    comp_t [2:0] c1;
    logic  [1:0] flag;
  } carry_t;

  prod_t [5:0] p1_r, p3_r;
  carry_t      k1_r, k2_r, k3_r, k4_r;
  comp_t [2:0] c2_r;

  logic [QXW-1:0] rt_rem_r  [QRW+1][4];
  logic [QRW-1:0] rt_root_r [QRW+1][4];
  logic [2:0]     rt_neg_r  [QRW+1];
  logic [1:0]     rt_flag_r [QRW+1];

  logic signed [AW-1:0] arg [4];
  logic signed [CW:0]   sd  [3];
  logic [63:0]          quat_r;
  logic [1:0]           flag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r[0] <= a_i[1] * m_i[2];
      p1_r[1] <= a_i[2] * m_i[1];
      p1_r[2] <= a_i[2] * m_i[0];
      p1_r[3] <= a_i[0] * m_i[2];
      p1_r[4] <= a_i[0] * m_i[1];
      p1_r[5] <= a_i[1] * m_i[0];
      k1_r.a    <= a_i;
      k1_r.c1   <= '0;
      k1_r.flag <= flag_i;
      k2_r.a    <= k1_r.a;
      k2_r.flag <= k1_r.flag;
      for (int k = 0; k < 3; k++) begin
        k2_r.c1[k] <= rescale(PDW'(p1_r[2*k]) - PDW'(p1_r[2*k+1]));
      end
      p3_r[0] <= k2_r.c1[1] * k2_r.a[2];
      p3_r[1] <= k2_r.c1[2] * k2_r.a[1];
      p3_r[2] <= k2_r.c1[2] * k2_r.a[0];
      p3_r[3] <= k2_r.c1[0] * k2_r.a[2];
      p3_r[4] <= k2_r.c1[0] * k2_r.a[1];
      p3_r[5] <= k2_r.c1[1] * k2_r.a[0];
      k3_r <= k2_r;
      for (int k = 0; k < 3; k++) begin
        c2_r[k] <= rescale(PDW'(p3_r[2*k]) - PDW'(p3_r[2*k+1]));
      end
      k4_r <= k3_r;
    end
  end

  always_comb begin
    arg[0] = AW'(c2_r[0]) + AW'(k4_r.c1[1]) + AW'(k4_r.a[2]) + AW'(ONE);
    arg[1] = AW'(c2_r[0]) - AW'(k4_r.c1[1]) - AW'(k4_r.a[2]) + AW'(ONE);
    arg[2] = AW'(k4_r.c1[1]) - AW'(k4_r.a[2]) - AW'(c2_r[0]) + AW'(ONE);
    arg[3] = AW'(k4_r.a[2]) - AW'(c2_r[0]) - AW'(k4_r.c1[1]) + AW'(ONE);
    sd[0]  = (CW+1)'(k4_r.c1[2]) - (CW+1)'(k4_r.a[1]);
    sd[1]  = (CW+1)'(k4_r.a[0]) - (CW+1)'(c2_r[2]);
    sd[2]  = (CW+1)'(c2_r[1]) - (CW+1)'(k4_r.c1[0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        rt_rem_r[0][k]  <= (arg[k] <= 0) ? '0 : (QXW'(arg[k]) << (F - 2));
        rt_root_r[0][k] <= '0;
      end
      for (int k = 0; k < 3; k++) begin
        rt_neg_r[0][k] <= sd[k][CW];
      end
      rt_flag_r[0] <= k4_r.flag;
    end
  end

  for (genvar s = 0; s < QRW; s++) begin : g_sqrt
    localparam int I = QRW - 1 - s;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 4; k++) begin
          if (QTW'(rt_rem_r[s][k]) >= ((QTW'(rt_root_r[s][k]) << (I + 1))
                                       | (QTW'(1) << (2 * I)))) begin
            rt_rem_r[s+1][k]  <= QXW'(QTW'(rt_rem_r[s][k])
                                 - ((QTW'(rt_root_r[s][k]) << (I + 1))
                                    | (QTW'(1) << (2 * I))));
            rt_root_r[s+1][k] <= rt_root_r[s][k] | (QRW'(1) << I);
          end else begin
            rt_rem_r[s+1][k]  <= rt_rem_r[s][k];
            rt_root_r[s+1][k] <= rt_root_r[s][k];
          end
        end
        rt_neg_r[s+1]  <= rt_neg_r[s];
        rt_flag_r[s+1] <= rt_flag_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [VW-1:0] mag;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        mag = signed'(VW'(rt_root_r[QRW][k]))
            + ((QTW'(rt_rem_r[QRW][k]) > QTW'(rt_root_r[QRW][k])) ? VW'(1) : VW'(0));
        if (k > 0 && rt_neg_r[QRW][k-1]) begin
          mag = -mag;
        end
        quat_r[16*k +: 16] <= pack16(mag);
      end
      flag_r <= rt_flag_r[QRW];
    end
  end

  assign quat_o = quat_r;
  assign flag_o = flag_r;

endmodule

// ===== sv/accel_mag_initial_quaternion_core.sv =====
// Top level: initial attitude quaternion from one accelerometer and magnetometer
// request. Instantiates amiq_norm (twice) and amiq_quat; depends on amiq_pkg.
//
//  port group   dir  payload
//  in_*         in   tdata[95:0] = accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
//  out_*        out  tdata[63:0] = quat_w..quat_z, tuser[1:0] = accel_zero, mag_zero
//
// One request enters per cycle unless the output stalls; at 14 fraction bits the
// pipeline holds the 31 root stages and 15 divide stages of the normalizer plus the
// 15 root stages of the quaternion extractor.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears only the valid chain.
module accel_mag_initial_quaternion_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic [1:0]  out_tuser   // accel_zero, mag_zero
);
  import amiq_pkg::*;

  logic [LAT-1:0] v_r;
  logic           en;
  raw_t  [2:0]    a_raw, m_raw;
  comp_t [2:0]    a_unit, m_unit;
  logic           a_zero, m_zero;

  assign en        = !v_r[LAT-1] || out_tready;
  assign in_tready = en;
  assign out_tvalid = v_r[LAT-1];

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign a_raw[k] = in_tdata[16*k +: 16];
    assign m_raw[k] = in_tdata[48 + 16*k +: 16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_tvalid};
    end
  end

  amiq_norm u_norm_a (.clk(clk), .en(en), .vec_i(a_raw), .unit_o(a_unit), .zero_o(a_zero));
  amiq_norm u_norm_m (.clk(clk), .en(en), .vec_i(m_raw), .unit_o(m_unit), .zero_o(m_zero));

  amiq_quat u_quat (
    .clk    (clk),
    .en     (en),
    .a_i    (a_unit),
    .m_i    (m_unit),
    .flag_i ({m_zero, a_zero}),
    .quat_o (out_tdata),
    .flag_o (out_tuser)
  );

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> v_r == $past(v_r))
    else $error("pipeline moved while stalled");

  a_w_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[15])
    else $error("quat_w negative");

  a_accel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[15:0] == pack16(VW'(ONE / 2)) && out_tdata[63:48] == pack16(VW'(ONE / 2)))
    else $error("zero accel vector gave wrong quaternion");

endmodule

// ===== verif/accel_mag_initial_quaternion_core_tb.sv =====
// Self-checking testbench for accel_mag_initial_quaternion_core: directed and random
// sensor requests, quaternions predicted in the bench. Depends on amiq_pkg and the core.
module accel_mag_initial_quaternion_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import amiq_pkg::*;

  typedef struct packed {
    logic [15:0] qw, qx, qy, qz;
    logic        az, mz;
  } quat_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  quat_res_t   quat_q[$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_got = 0;
  int          n_zero = 0;
  bit          hold_off = 1'b0;

  accel_mag_initial_quaternion_core u_dut (.*);

  always #6 clk = ~clk;

  function automatic longint isqrt_fl(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clamp1(longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic longint round_shift(longint v);
    longint u;
    u = (v < 0) ? -v : v;
    u = (u + (1 << (F - 1))) >>> F;
    return clamp1((v < 0) ? -u : u);
  endfunction

  function automatic bit unit_vec(ref longint v[3]);
    longint unsigned s, root, mag, q;
    s = 0;
    for (int i = 0; i < 3; i++) s += v[i] * v[i];
    if (s == 0) return 1'b1;
    root = isqrt_fl(s << 30);
    for (int i = 0; i < 3; i++) begin
      mag = (v[i] < 0) ? -v[i] : v[i];
      q = (mag * (64'd1 << (F + 15)) + root / 2) / root;
      if (q > ONE) q = ONE;
      v[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic longint half_root(longint arg);
    longint unsigned x, r;
    if (arg <= 0) return 0;
    x = arg << (F - 2);
    r = isqrt_fl(x);
    if (x - r * r > r) r++;
    return r;
  endfunction

  function automatic logic [15:0] sat16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic quat_res_t predict_quat(logic [95:0] d);
    longint a[3], m[3], c1[3], c2[3], w, x, y, z;
    quat_res_t r;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(d[16*i +: 16]));
      m[i] = longint'($signed(d[16*(i+3) +: 16]));
    end
    r.az = unit_vec(a);
    r.mz = unit_vec(m);
    c1[0] = round_shift(a[1] * m[2] - a[2] * m[1]);
    c1[1] = round_shift(a[2] * m[0] - a[0] * m[2]);
    c1[2] = round_shift(a[0] * m[1] - a[1] * m[0]);
    c2[0] = round_shift(c1[1] * a[2] - c1[2] * a[1]);
    c2[1] = round_shift(c1[2] * a[0] - c1[0] * a[2]);
    c2[2] = round_shift(c1[0] * a[1] - c1[1] * a[0]);
    w = half_root(c2[0] + c1[1] + a[2] + ONE);
    x = half_root(c2[0] - c1[1] - a[2] + ONE);
    y = half_root(c1[1] - a[2] - c2[0] + ONE);
    z = half_root(a[2] - c2[0] - c1[1] + ONE);
    if (c1[2] - a[1] < 0) x = -x;
    if (a[0] - c2[2] < 0) y = -y;
    if (c2[1] - c1[0] < 0) z = -z;
    r.qw = sat16(w);
    r.qx = sat16(x);
    r.qy = sat16(y);
    r.qz = sat16(z);
    return r;
  endfunction

  task automatic send_sample(logic [95:0] d, int max_gap);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    quat_q.push_back(predict_quat(d));
    n_sent++;
    if (d[47:0] == '0 || d[95:48] == '0) n_zero++;
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [95:0] rand_sample();
    logic [95:0] d;
    for (int i = 0; i < 6; i++) d[16*i +: 16] = rand_axis();
    if ($urandom_range(0, 19) == 0) d[47:0] = '0;
    if ($urandom_range(0, 19) == 0) d[95:48] = '0;
    return d;
  endfunction

  task automatic test_extremes();
    logic [15:0] ext[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff};
    send_sample('0, 0);
    send_sample({48'h0, 16'h4000, 16'h0000, 16'h0000}, 0);
    send_sample({16'h0000, 16'h0000, 16'h4000, 48'h0}, 0);
    send_sample({48'h0001_0000_0000, 16'h4000, 16'h0000, 16'h0000}, 0);
    send_sample({48'h0000_0000_4000, 48'h0000_0000_4000}, 0);
    send_sample({48'h0000_0000_c000, 48'h0000_0000_4000}, 0);
    send_sample({48'h0000_0000_4000, 48'h0000_4000_0000}, 0);
    send_sample({48'h4000_0000_0000, 48'h0000_c000_0000}, 0);
    send_sample({48'hc000_0000_0000, 48'h0000_4000_0000}, 0);
    send_sample({48'h0000_4000_0000, 48'hc000_0000_0000}, 0);
    for (int i = 0; i < 5; i++)
      send_sample({ext[(i+1)%5], ext[(i+2)%5], ext[i], ext[(i+3)%5], ext[i], ext[(i+4)%5]}, 1);
    send_sample({6{16'h8000}}, 0);
    send_sample({6{16'h7fff}}, 0);
    send_sample({48'h8000_7fff_0001, 48'hffff_8000_7fff}, 0);
  endtask

  task automatic test_random(int n, int max_gap);
    repeat (n) send_sample(rand_sample(), $urandom_range(0, 1) ? max_gap : 0);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(150, 0);
    join
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        quat_res_t got, exp_r;
        got = '{out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tdata[63:48],
                out_tuser[0], out_tuser[1]};
        n_got++;
        if (quat_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_r = quat_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: expected w=%h x=%h y=%h z=%h az=%b mz=%b", $time,
                     exp_r.qw, exp_r.qx, exp_r.qy, exp_r.qz, exp_r.az, exp_r.mz);
            $display("%0t: actual   w=%h x=%h y=%h z=%h az=%b mz=%b", $time,
                     got.qw, got.qx, got.qy, got.qz, got.az, got.mz);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int wait_cnt;
    wait_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (wait_cnt > 0) begin
        wait_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && out_tready && $urandom_range(0, 2) == 0)
          wait_cnt = $urandom_range(0, 12);
      end
    end
  end

  initial begin
    #2ms;
    $display("accel_mag_initial_quaternion_core: mismatch");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_random(700, 12);
    test_backpressure();
    test_random(700, 0);
    in_tvalid <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk);
    repeat (2 * LAT) @(posedge clk);
    $display("Sent %0d sensor requests (%0d with a zero vector), checked %0d quaternions.",
             n_sent, n_zero, n_got);
    if (errors == 0 && quat_q.size() == 0)
      $display("accel_mag_initial_quaternion_core: match");
    else
      $display("accel_mag_initial_quaternion_core: mismatch");
    $finish;
  end
endmodule
